>>> rtl/ctb_pkg.sv
// ----------------------------------------------------------------------------
// ctb_pkg: shared types and constants of the countdown timer bank
// Action codes, the command word carried from front to back, and the status
// group exported by the back end.
// ----------------------------------------------------------------------------
package ctb_pkg;

  localparam int SLOTS         = 16;
  localparam int SLOT_AW       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int SLOT_FIELD_W  = 4;
  localparam int PERIOD_W      = 16;
  localparam int ELAPSED_W     = 16;
  localparam int SOUND_W       = 2;
  localparam int LOAD_W        = 26;
  localparam int MS_PER_SECOND = 1000;
  localparam int MAX_RESULTS   = 16;
  localparam int RES_CW        = $clog2(MAX_RESULTS + 1);
  localparam int QDEPTH        = 2;
  localparam int QAW           = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCW           = $clog2(QDEPTH + 1);

  typedef enum logic [2:0] {
    ACT_ADD       = 3'd0,
    ACT_REMOVE    = 3'd1,
    ACT_START     = 3'd2,
    ACT_STOP      = 3'd3,
    ACT_RESET     = 3'd4,
    ACT_START_ALL = 3'd5,
    ACT_STOP_ALL  = 3'd6,
    ACT_TICK      = 3'd7
  } ctb_action_t;

  typedef struct packed {
    ctb_action_t            action;
    logic                   hit;      // slot number lies inside the bank
    logic [SLOT_AW-1:0]     idx;
    logic [LOAD_W-1:0]      load_ms;  // period already scaled to ms
    logic                   rep;
    logic [SOUND_W-1:0]     snd;
    logic [ELAPSED_W-1:0]   elapsed;
  } ctb_cmd_t;

  typedef struct packed {
    logic sweeping;    // back end busy with a tick
    logic pend_valid;  // an expiry result held back until the next one is known
  } ctb_status_t;

endpackage

>>> rtl/ctb_front.sv
// ----------------------------------------------------------------------------
// ctb_front: command decode
// Classify the incoming beat, range-check the slot and scale the period to ms.
// ----------------------------------------------------------------------------
module ctb_front (
  input  logic [2:0]                  in_action,
  input  logic [3:0]                  in_slot,
  input  logic [15:0]                 in_period_seconds,
  input  logic                        in_repeat_mode,
  input  logic [1:0]                  in_alert_sound,
  input  logic [15:0]                 in_elapsed_ms,
  output ctb_pkg::ctb_cmd_t           cmd
);
  import ctb_pkg::*;

  always_comb begin
    cmd.action  = ctb_action_t'(in_action);
    cmd.hit     = int'(in_slot) < SLOTS;
    cmd.idx     = SLOT_AW'(in_slot);
    cmd.load_ms = LOAD_W'(in_period_seconds) * LOAD_W'(MS_PER_SECOND);
    cmd.rep     = in_repeat_mode;
    cmd.snd     = in_alert_sound;
    cmd.elapsed = in_elapsed_ms;
  end

endmodule

>>> rtl/ctb_queue.sv
// ----------------------------------------------------------------------------
// ctb_queue: command queue
// Short register FIFO that decouples command decode from execution.
// ----------------------------------------------------------------------------
module ctb_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  output logic              push_ready,
  input  ctb_pkg::ctb_cmd_t push_data,
  output logic              pop_valid,
  input  logic              pop_ready,
  output ctb_pkg::ctb_cmd_t pop_data
);
  import ctb_pkg::*;

  ctb_cmd_t         ent_r [QDEPTH];
  logic [QAW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0]   count_r, count_nxt;
  logic             push_fire, pop_fire;

  assign push_ready = count_r != QCW'(QDEPTH);
  assign pop_valid  = count_r != '0;
  assign pop_data   = ent_r[rd_ptr_r];
  assign push_fire  = push_valid && push_ready;
  assign pop_fire   = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push_fire) begin
      wr_ptr_nxt = (wr_ptr_r == QAW'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop_fire) begin
      rd_ptr_nxt = (rd_ptr_r == QAW'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push_fire, pop_fire})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (push_fire) begin
      ent_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

>>> rtl/ctb_back.sv
// ----------------------------------------------------------------------------
// ctb_back: timer execution
// Hold slot state, run one command at a time, sweep the slots one per cycle on
// a tick (stalling on a full output register), emitting expiry beats there.
// ----------------------------------------------------------------------------
module ctb_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cmd_valid,
  output logic                  cmd_ready,
  input  ctb_pkg::ctb_cmd_t     cmd,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [3:0]            out_expired_slot,
  output logic [1:0]            out_expired_sound,
  output logic                  out_last_of_run,
  output ctb_pkg::ctb_status_t  status
);
  import ctb_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_SWEEP, ST_FLUSH} state_t;

  state_t                 state_r, state_nxt;
  logic [SLOTS-1:0]       valid_r, valid_nxt;
  logic [SLOTS-1:0]       run_r, run_nxt;
  logic                   rep_r  [SLOTS];
  logic [LOAD_W-1:0]      load_r [SLOTS];
  logic [LOAD_W-1:0]      rem_r  [SLOTS];
  logic [SOUND_W-1:0]     snd_r  [SLOTS];
  logic [SLOT_AW-1:0]     cnt_r, cnt_nxt;
  logic [ELAPSED_W-1:0]   el_r, el_nxt;
  logic [RES_CW-1:0]      res_r, res_nxt;
  logic                   pend_v_r, pend_v_nxt;
  logic [3:0]             pend_slot_r, pend_slot_nxt;
  logic [SOUND_W-1:0]     pend_snd_r, pend_snd_nxt;
  logic                   out_v_r, out_v_nxt;
  logic [3:0]             out_slot_r, out_slot_nxt;
  logic [SOUND_W-1:0]     out_snd_r, out_snd_nxt;
  logic                   out_last_r, out_last_nxt;

  logic [SLOT_AW-1:0]     rd_idx;
  logic [LOAD_W-1:0]      rd_rem, rd_load, el_ext;
  logic                   rd_rep;
  logic [SOUND_W-1:0]     rd_snd;
  logic                   rem_we, add_we, out_free, active, expire, stall;
  logic [LOAD_W-1:0]      rem_wdata;

  assign rd_idx  = (state_r == ST_IDLE) ? cmd.idx : cnt_r;
  assign rd_rem  = rem_r[rd_idx];
  assign rd_load = load_r[rd_idx];
  assign rd_rep  = rep_r[rd_idx];
  assign rd_snd  = snd_r[rd_idx];
  assign el_ext  = LOAD_W'(el_r);

  assign out_free  = !out_v_r || out_ready;
  assign cmd_ready = state_r == ST_IDLE;
  assign active    = valid_r[rd_idx] && run_r[rd_idx];
  assign expire    = active && (rd_rem <= el_ext);
  assign stall     = expire && pend_v_r && !out_free;

  always_comb begin
    state_nxt     = state_r;
    valid_nxt     = valid_r;
    run_nxt       = run_r;
    cnt_nxt       = cnt_r;
    el_nxt        = el_r;
    res_nxt       = res_r;
    pend_v_nxt    = pend_v_r;
    pend_slot_nxt = pend_slot_r;
    pend_snd_nxt  = pend_snd_r;
    out_v_nxt     = out_v_r && !out_ready;
    out_slot_nxt  = out_slot_r;
    out_snd_nxt   = out_snd_r;
    out_last_nxt  = out_last_r;
    rem_we        = 1'b0;
    add_we        = 1'b0;
    rem_wdata     = rd_load;

    unique case (state_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          unique case (cmd.action) inside
            ACT_ADD: begin
              if (cmd.hit) begin
                valid_nxt[rd_idx] = 1'b1;
                run_nxt[rd_idx]   = 1'b0;
                add_we            = 1'b1;
                rem_we            = 1'b1;
                rem_wdata         = cmd.load_ms;
              end
            end
            ACT_REMOVE: begin
              if (cmd.hit) begin
                valid_nxt[rd_idx] = 1'b0;
                run_nxt[rd_idx]   = 1'b0;
              end
            end
            ACT_START, ACT_STOP: begin
              if (cmd.hit && valid_r[rd_idx]) begin
                run_nxt[rd_idx] = cmd.action == ACT_START;
              end
            end
            ACT_RESET: begin
              if (cmd.hit && valid_r[rd_idx]) begin
                run_nxt[rd_idx] = 1'b0;
                rem_we          = 1'b1;
                rem_wdata       = rd_load;
              end
            end
            ACT_START_ALL, ACT_STOP_ALL: begin
              for (int i = 0; i < SLOTS; i++) begin
                if (valid_r[i]) begin
                  run_nxt[i] = cmd.action == ACT_START_ALL;
                end
              end
            end
            ACT_TICK: begin
              state_nxt  = ST_SWEEP;
              cnt_nxt    = '0;
              el_nxt     = cmd.elapsed;
              res_nxt    = '0;
              pend_v_nxt = 1'b0;
            end
            default: ;
          endcase
        end
      end
      ST_SWEEP: begin
        if (!stall) begin
          if (active) begin
            rem_we = 1'b1;
            if (!expire) begin
              rem_wdata = rd_rem - el_ext;
            end else begin
              if (rd_rep) begin
                rem_wdata = rd_load;
              end else begin
                rem_wdata       = '0;
                run_nxt[rd_idx] = 1'b0;
              end
              if (res_r < RES_CW'(MAX_RESULTS)) begin
                // Push the held result out; this one becomes the held one.
                if (pend_v_r) begin
                  out_v_nxt    = 1'b1;
                  out_slot_nxt = pend_slot_r;
                  out_snd_nxt  = pend_snd_r;
                  out_last_nxt = 1'b0;
                end
                pend_v_nxt    = 1'b1;
                pend_slot_nxt = 4'(rd_idx);
                pend_snd_nxt  = rd_snd;
                res_nxt       = res_r + 1'b1;
              end
            end
          end
          if (cnt_r == SLOT_AW'(SLOTS - 1)) begin
            state_nxt = ST_FLUSH;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
      end
      ST_FLUSH: begin
        if (!pend_v_r) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          out_v_nxt    = 1'b1;
          out_slot_nxt = pend_slot_r;
          out_snd_nxt  = pend_snd_r;
          out_last_nxt = 1'b1;
          pend_v_nxt   = 1'b0;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      valid_r  <= '0;
      run_r    <= '0;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
      res_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      valid_r  <= valid_nxt;
      run_r    <= run_nxt;
      pend_v_r <= pend_v_nxt;
      out_v_r  <= out_v_nxt;
      res_r    <= res_nxt;
    end
    cnt_r       <= cnt_nxt;
    el_r        <= el_nxt;
    pend_slot_r <= pend_slot_nxt;
    pend_snd_r  <= pend_snd_nxt;
    out_slot_r  <= out_slot_nxt;
    out_snd_r   <= out_snd_nxt;
    out_last_r  <= out_last_nxt;
    if (rem_we) begin
      rem_r[rd_idx] <= rem_wdata;
    end
    if (add_we) begin
      load_r[rd_idx] <= cmd.load_ms;
      rep_r[rd_idx]  <= cmd.rep;
      snd_r[rd_idx]  <= cmd.snd;
    end
  end

  assign out_valid         = out_v_r;
  assign out_expired_slot  = out_slot_r;
  assign out_expired_sound = out_snd_r;
  assign out_last_of_run   = out_last_r;
  assign status.sweeping   = state_r != ST_IDLE;
  assign status.pend_valid = pend_v_r;

endmodule

>>> rtl/countdown_timer_bank.sv
// ----------------------------------------------------------------------------
// countdown_timer_bank: bank of SLOTS countdown timers addressed by slot
// A beat is registered in the two-entry queue before it reaches the executor;
//   add, remove, start, stop, reset and start/stop all are carried out there.
// A tick holds the executor as it takes it, steps one slot per cycle through
//   the single read port (pausing on an output stall) and closes the run;
//   in_ready stays high while the two-entry queue has room.
// Reset: synchronous; empties every slot, drops queued commands and results.
// ----------------------------------------------------------------------------
module countdown_timer_bank (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_action,
  input  logic [3:0]  in_slot,
  input  logic [15:0] in_period_seconds,
  input  logic        in_repeat_mode,
  input  logic [1:0]  in_alert_sound,
  input  logic [15:0] in_elapsed_ms,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_expired_slot,
  output logic [1:0]  out_expired_sound,
  output logic        out_last_of_run
);
  import ctb_pkg::*;

  ctb_cmd_t    dec_cmd;
  ctb_cmd_t    q_pop_data;
  logic        q_pop_valid;
  logic        q_pop_ready;
  ctb_status_t bk_status;

  // Decode the input beat and scale the period to milliseconds.
  ctb_front u_front (
    .in_action         (in_action),
    .in_slot           (in_slot),
    .in_period_seconds (in_period_seconds),
    .in_repeat_mode    (in_repeat_mode),
    .in_alert_sound    (in_alert_sound),
    .in_elapsed_ms     (in_elapsed_ms),
    .cmd               (dec_cmd)
  );

  // Hold decoded commands so input keeps flowing during a tick sweep.
  ctb_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_valid),
    .push_ready (in_ready),
    .push_data  (dec_cmd),
    .pop_valid  (q_pop_valid),
    .pop_ready  (q_pop_ready),
    .pop_data   (q_pop_data)
  );

  // Execute commands; expiry beats leave through a registered output stage.
  // The newest expiry is held back one step so the final beat of a tick can
  // be marked once the sweep has passed the last slot.
  ctb_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd_valid         (q_pop_valid),
    .cmd_ready         (q_pop_ready),
    .cmd               (q_pop_data),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_expired_slot  (out_expired_slot),
    .out_expired_sound (out_expired_sound),
    .out_last_of_run   (out_last_of_run),
    .status            (bk_status)
  );

  // No new command may start while an expiry of the previous tick is held.
  a_no_pop_with_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop_valid && q_pop_ready) |-> !bk_status.pend_valid)
    else $error("command popped while an expiry result is still held");

  // A waiting non-final beat implies its successor is already held back.
  a_nonlast_has_successor: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last_of_run) |-> bk_status.pend_valid)
    else $error("non-final expiry beat without a following result");

  // A sweep starts only from a popped tick command.
  a_sweep_from_tick: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(bk_status.sweeping) |->
      $past(q_pop_valid && q_pop_ready && q_pop_data.action == ACT_TICK))
    else $error("sweep started without a tick command");

  // Results are only produced by a sweep in progress or its closing step.
  a_result_from_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(bk_status.sweeping))
    else $error("expiry beat appeared outside a tick sweep");

endmodule
